// ----- sv/gep_pkg.sv -----
`default_nettype none

package gep_pkg;

    localparam int MAX_BANDS   = 31;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;

    localparam int BAND_BITS  = SAMPLE_BITS + 8;
    localparam int COEF_FRAC  = COEF_BITS - 2;
    localparam int GAIN_FRAC  = COEF_BITS - 4;
    localparam int BAND_AW    = $clog2(MAX_BANDS);
    localparam int WORD_BITS  = 32;
    localparam int INDEX_BITS = 5;
    localparam int COUNT_BITS = 5;
    localparam int NUM_WORDS  = 4;

    localparam int HIST_W = 2 * SAMPLE_BITS + 2 * BAND_BITS;
    localparam int PROD_W = COEF_BITS + BAND_BITS;

    localparam int IN_FIELDS_W = 2 * SAMPLE_BITS + INDEX_BITS + WORD_BITS;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int IN_USER_W   = 4;

    localparam logic [63:0] GAIN_RESET_W =
        (64'd636 * (64'd1 << GAIN_FRAC) + 64'd500) / 64'd1000;
    localparam logic [COEF_BITS-1:0] GAIN_RESET = COEF_BITS'(GAIN_RESET_W);

    localparam logic [1:0] MODE_FRAME = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] WSEL_C1   = 2'd0;
    localparam logic [1:0] WSEL_C2   = 2'd1;
    localparam logic [1:0] WSEL_C3   = 2'd2;
    localparam logic [1:0] WSEL_GAIN = 2'd3;

    localparam int         REG_IDX_W      = 1;
    localparam int         REG_DATA_W     = COUNT_BITS;
    localparam logic [0:0] REG_ENABLE     = 1'b0;
    localparam logic [0:0] REG_BAND_COUNT = 1'b1;

    localparam logic [COUNT_BITS-1:0] BAND_COUNT_RESET = 5'd10;

    typedef struct packed {
        logic               rd_en;
        logic               first;
        logic               last;
        logic               clear;
        logic [BAND_AW-1:0] addr;
    } t_lane_ctl;

    typedef struct packed {
        logic [COEF_BITS-1:0] c1;
        logic [COEF_BITS-1:0] c2;
        logic [COEF_BITS-1:0] c3;
        logic [COEF_BITS-1:0] gain;
    } t_coef;

    typedef struct packed {
        logic                 we;
        logic [1:0]           sel;
        logic [BAND_AW-1:0]   addr;
        logic [COEF_BITS-1:0] data;
    } t_coef_wr;

endpackage

`default_nettype wire

// ----- sv/gep_ram.sv -----
`default_nettype none

module gep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/gep_coef_bank.sv -----
`default_nettype none

module gep_coef_bank (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire gep_pkg::t_coef_wr  i_wr,
    input  wire gep_pkg::t_lane_ctl i_ctl,
    output gep_pkg::t_coef       o_coef
);

    logic [gep_pkg::COEF_BITS-1:0] w_rdata [gep_pkg::NUM_WORDS];
    logic                          w_vq    [gep_pkg::NUM_WORDS];

    for (genvar k = 0; k < gep_pkg::NUM_WORDS; k++) begin : g_word
        logic                          w_we;
        logic [gep_pkg::MAX_BANDS-1:0] r_cv;
        logic                          r_cvq;

        assign w_we = i_wr.we && (i_wr.sel == 2'(k));

        gep_ram #(
            .WIDTH (gep_pkg::COEF_BITS),
            .DEPTH (gep_pkg::MAX_BANDS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (i_wr.addr),
            .i_wdata (i_wr.data),
            .i_re    (i_ctl.rd_en),
            .i_raddr (i_ctl.addr),
            .o_rdata (w_rdata[k])
        );

        // written entries only, unwritten ones read as reset value
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv <= '0;
            end else if (w_we) begin
                r_cv[i_wr.addr] <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.rd_en) begin
                r_cvq <= r_cv[i_ctl.addr];
            end
        end

        assign w_vq[k] = r_cvq;
    end

    always_comb begin
        o_coef.c1   = w_vq[gep_pkg::WSEL_C1]   ? w_rdata[gep_pkg::WSEL_C1]   : '0;
        o_coef.c2   = w_vq[gep_pkg::WSEL_C2]   ? w_rdata[gep_pkg::WSEL_C2]   : '0;
        o_coef.c3   = w_vq[gep_pkg::WSEL_C3]   ? w_rdata[gep_pkg::WSEL_C3]   : '0;
        o_coef.gain = w_vq[gep_pkg::WSEL_GAIN] ? w_rdata[gep_pkg::WSEL_GAIN]
                                               : gep_pkg::GAIN_RESET;
    end

endmodule

`default_nettype wire

// ----- sv/gep_lane.sv -----
`default_nettype none

module gep_lane (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire gep_pkg::t_lane_ctl             i_ctl,
    input  wire gep_pkg::t_coef                 i_coef,
    input  wire signed [gep_pkg::SAMPLE_BITS-1:0] i_x,
    output logic                                o_done,
    output logic [gep_pkg::SAMPLE_BITS-1:0]     o_y
);

    localparam int SB     = gep_pkg::SAMPLE_BITS;
    localparam int BB     = gep_pkg::BAND_BITS;
    localparam int CB     = gep_pkg::COEF_BITS;
    localparam int AW     = gep_pkg::BAND_AW;
    localparam int HW     = gep_pkg::HIST_W;
    localparam int PW     = gep_pkg::PROD_W;
    localparam int DIFF_W = SB + 1;
    localparam int SUM_W  = PW + 2;
    localparam int SH_W   = SUM_W - gep_pkg::COEF_FRAC;
    localparam int ACC_W  = PW + $clog2(gep_pkg::MAX_BANDS) + 1;
    localparam int OSH_W  = ACC_W - gep_pkg::GAIN_FRAC;

    localparam logic signed [SUM_W-1:0] RND_B = SUM_W'(1) << (gep_pkg::COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] RND_G = ACC_W'(1) << (gep_pkg::GAIN_FRAC - 1);

    function automatic logic [BB-1:0] sat_band(input logic [SH_W-1:0] v);
        logic [SH_W-BB:0] top;
        top = v[SH_W-1:BB-1];
        if ((&top) || !(|top)) begin
            sat_band = v[BB-1:0];
        end else if (v[SH_W-1]) begin
            sat_band = {1'b1, {(BB-1){1'b0}}};
        end else begin
            sat_band = {1'b0, {(BB-1){1'b1}}};
        end
    endfunction

    function automatic logic [SB-1:0] sat_out(input logic [OSH_W-1:0] v);
        logic [OSH_W-SB:0] top;
        top = v[OSH_W-1:SB-1];
        if ((&top) || !(|top)) begin
            sat_out = v[SB-1:0];
        end else if (v[OSH_W-1]) begin
            sat_out = {1'b1, {(SB-1){1'b0}}};
        end else begin
            sat_out = {1'b0, {(SB-1){1'b1}}};
        end
    endfunction

    // history valid bits, cleared at once
    logic [gep_pkg::MAX_BANDS-1:0] r_hv;

    // stage 1: ram read
    logic          r_s1_vld, r_s1_first, r_s1_last, r_s1_hv;
    logic [AW-1:0] r_s1_addr;
    logic [HW-1:0] w_rdata, w_hist_q, w_hist;

    logic signed [SB-1:0]     w_x1, w_x2;
    logic signed [BB-1:0]     w_y1, w_y2, w_d_ext;
    logic signed [DIFF_W-1:0] w_d;
    logic signed [CB-1:0]     w_c1, w_c2, w_c3;
    logic signed [PW-1:0]     w_m1, w_m2, w_m3;

    // stage 2: products
    logic                 r_s2_vld, r_s2_first, r_s2_last;
    logic [AW-1:0]        r_s2_addr;
    logic signed [PW-1:0] r_p1, r_p2, r_p3;
    logic [SB-1:0]        r_s2_x1;
    logic [BB-1:0]        r_s2_y1;
    logic [CB-1:0]        r_s2_gain;

    logic signed [SUM_W-1:0] w_sum;

    // stage 3: band output, history write-back
    logic                 r_s3_vld, r_s3_first, r_s3_last;
    logic [AW-1:0]        r_s3_addr;
    logic [BB-1:0]        r_s3_y;
    logic [SB-1:0]        r_s3_x1;
    logic [BB-1:0]        r_s3_y1;
    logic [CB-1:0]        r_s3_gain;
    logic signed [PW-1:0] w_g;

    // stage 4: gain product, then accumulate
    logic                    r_s4_vld, r_s4_first, r_s4_last;
    logic signed [PW-1:0]    r_g;
    logic signed [ACC_W-1:0] r_acc, w_acc_r;
    logic                    r_done;

    gep_ram #(
        .WIDTH (HW),
        .DEPTH (gep_pkg::MAX_BANDS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_s3_vld),
        .i_waddr (r_s3_addr),
        .i_wdata (w_hist),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.addr),
        .o_rdata (w_rdata)
    );

    assign w_hist_q = r_s1_hv ? w_rdata : '0;
    assign w_x1     = $signed(w_hist_q[SB-1:0]);
    assign w_x2     = $signed(w_hist_q[2*SB-1:SB]);
    assign w_y1     = $signed(w_hist_q[2*SB+BB-1:2*SB]);
    assign w_y2     = $signed(w_hist_q[HW-1:2*SB+BB]);
    assign w_c1     = $signed(i_coef.c1);
    assign w_c2     = $signed(i_coef.c2);
    assign w_c3     = $signed(i_coef.c3);
    assign w_d      = DIFF_W'(i_x) - DIFF_W'(w_x2);
    assign w_d_ext  = BB'(w_d);
    assign w_m1     = w_c3 * w_y1;
    assign w_m2     = w_c2 * w_d_ext;
    assign w_m3     = w_c1 * w_y2;

    assign w_sum = SUM_W'(r_p1) + SUM_W'(r_p2) - SUM_W'(r_p3) + RND_B;

    assign w_hist = {r_s3_y1, r_s3_y, r_s3_x1, i_x};
    assign w_g    = $signed(r_s3_y) * $signed(r_s3_gain);

    assign w_acc_r = r_acc + RND_G;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv     <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_hv <= '0;
            end else if (r_s3_vld) begin
                r_hv[r_s3_addr] <= 1'b1;
            end
            r_s1_vld <= i_ctl.rd_en;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_done   <= r_s4_vld && r_s4_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hv    <= r_hv[i_ctl.addr];
        r_s1_addr  <= i_ctl.addr;
        r_s1_first <= i_ctl.first;
        r_s1_last  <= i_ctl.last;

        r_p1       <= w_m1;
        r_p2       <= w_m2;
        r_p3       <= w_m3;
        r_s2_x1    <= w_x1;
        r_s2_y1    <= w_y1;
        r_s2_gain  <= i_coef.gain;
        r_s2_addr  <= r_s1_addr;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;

        r_s3_y     <= sat_band(w_sum[SUM_W-1:gep_pkg::COEF_FRAC]);
        r_s3_x1    <= r_s2_x1;
        r_s3_y1    <= r_s2_y1;
        r_s3_gain  <= r_s2_gain;
        r_s3_addr  <= r_s2_addr;
        r_s3_first <= r_s2_first;
        r_s3_last  <= r_s2_last;

        r_g        <= w_g;
        r_s4_first <= r_s3_first;
        r_s4_last  <= r_s3_last;

        if (r_s4_vld) begin
            r_acc <= r_s4_first ? ACC_W'(r_g) : r_acc + ACC_W'(r_g);
        end
    end

    assign o_done = r_done;
    assign o_y    = sat_out(w_acc_r[ACC_W-1:gep_pkg::GAIN_FRAC]);

endmodule

`default_nettype wire

// ----- sv/parallel_bandpass_graphic_equalizer_top.sv -----
// channel     dir  beat fields, lowest bit first
// s_axis      in   tdata: left_in, right_in, band_index, word_value; tuser: mode, word_select
// m_axis      out  tdata: left_out, right_out
// i_cfg_*     in   index 0 enable, index 1 band_count
//
// filtered frame: one band per cycle through each channel lane and its history ram port
// pass-through frame skips the channel lanes; band word load and history clear stay in idle
// reset is synchronous: history and coefficient entries read as reset values at once
// a waiting result beat is held in the output register; the next beat is still taken
`default_nettype none

module parallel_bandpass_graphic_equalizer_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire [gep_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // left_in, right_in, band_index, word_value
    input  wire [gep_pkg::IN_USER_W-1:0]       s_axis_tuser,  // mode, word_select
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [gep_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // left_out, right_out
    input  wire                                i_cfg_we,
    input  wire [gep_pkg::REG_IDX_W-1:0]       i_cfg_addr,
    input  wire [gep_pkg::REG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int SB = gep_pkg::SAMPLE_BITS;
    localparam int AW = gep_pkg::BAND_AW;
    localparam int IB = gep_pkg::INDEX_BITS;
    localparam int WB = gep_pkg::WORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_HOLD
    } t_state;

    t_state r_state;

    logic                             r_enable;
    logic [gep_pkg::COUNT_BITS-1:0]   r_band_count;
    logic [AW-1:0]                    r_band;
    logic signed [SB-1:0]             r_x_l, r_x_r;
    logic [SB-1:0]                    r_res_l, r_res_r;
    logic                             r_m_valid;
    logic [gep_pkg::OUT_DATA_W-1:0]   r_m_data;

    logic          w_accept, w_filter, w_count_ok, w_last, w_clear, w_en_rise, w_done;
    logic [1:0]    w_mode, w_wsel;
    logic [SB-1:0] w_left, w_right, w_yl, w_yr;
    logic [IB-1:0] w_bidx;
    logic [WB-1:0] w_word;
    logic          w_l_done, w_r_done;

    gep_pkg::t_lane_ctl w_ctl;
    gep_pkg::t_coef     w_coef;
    gep_pkg::t_coef_wr  w_wr;

    assign w_mode  = s_axis_tuser[1:0];
    assign w_wsel  = s_axis_tuser[3:2];
    assign w_left  = s_axis_tdata[SB-1:0];
    assign w_right = s_axis_tdata[2*SB-1:SB];
    assign w_bidx  = s_axis_tdata[2*SB+IB-1:2*SB];
    assign w_word  = s_axis_tdata[2*SB+IB+WB-1:2*SB+IB];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_count_ok = (r_band_count inside {5'd10, 5'd15, 5'd25, 5'd31})
                        && (32'(r_band_count) <= gep_pkg::MAX_BANDS);
    assign w_filter   = r_enable && w_count_ok;
    assign w_last     = (r_band == AW'(r_band_count - 5'd1));
    assign w_en_rise  = i_cfg_we && (i_cfg_addr == gep_pkg::REG_ENABLE)
                        && i_cfg_wdata[0] && !r_enable;
    assign w_clear    = (w_accept && (w_mode == gep_pkg::MODE_CLEAR)) || w_en_rise;
    assign w_done     = w_l_done && w_r_done;

    always_comb begin
        w_ctl.rd_en = (r_state == S_RUN);
        w_ctl.first = (r_band == '0);
        w_ctl.last  = w_last;
        w_ctl.clear = w_clear;
        w_ctl.addr  = r_band;
    end

    always_comb begin
        w_wr.we   = w_accept && (w_mode == gep_pkg::MODE_LOAD)
                    && (32'(w_bidx) < gep_pkg::MAX_BANDS);
        w_wr.sel  = w_wsel;
        w_wr.addr = w_bidx[AW-1:0];
        w_wr.data = gep_pkg::COEF_BITS'($signed(w_word));
    end

    gep_coef_bank u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_ctl   (w_ctl),
        .o_coef  (w_coef)
    );

    gep_lane u_lane_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coef  (w_coef),
        .i_x     (r_x_l),
        .o_done  (w_l_done),
        .o_y     (w_yl)
    );

    gep_lane u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coef  (w_coef),
        .i_x     (r_x_r),
        .o_done  (w_r_done),
        .o_y     (w_yr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_enable     <= 1'b0;
            r_band_count <= gep_pkg::BAND_COUNT_RESET;
            r_band       <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    gep_pkg::REG_ENABLE: begin
                        r_enable <= i_cfg_wdata[0];
                    end
                    gep_pkg::REG_BAND_COUNT: begin
                        r_band_count <= i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end

            if ((r_state == S_HOLD) && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_mode == gep_pkg::MODE_FRAME)) begin
                        r_x_l <= $signed(w_left);
                        r_x_r <= $signed(w_right);
                        if (w_filter) begin
                            r_band  <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_res_l <= w_left;
                            r_res_r <= w_right;
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_RUN: begin
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_band <= r_band + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (w_done) begin
                        r_res_l <= w_yl;
                        r_res_r <= w_yr;
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= gep_pkg::OUT_DATA_W'({r_res_r, r_res_l});
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// ----- test/parallel_bandpass_graphic_equalizer_top_tb.sv -----
`timescale 1ns / 100ps

module parallel_bandpass_graphic_equalizer_top_tb;

    localparam logic [1:0] MODE_NOP      = 2'd3;
    localparam int         SETTLE_CYCLES = gep_pkg::MAX_BANDS + 17;
    localparam int         HOLD_CYCLES   = 300;

    typedef logic signed [95:0]                     t_wide;
    typedef logic signed [gep_pkg::SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [gep_pkg::COEF_BITS-1:0]   t_word;
    typedef logic signed [gep_pkg::BAND_BITS-1:0]   t_band;
    typedef logic [gep_pkg::INDEX_BITS-1:0]         t_index;
    typedef logic [gep_pkg::REG_DATA_W-1:0]         t_regval;
    typedef logic [gep_pkg::IN_DATA_W-1:0]          t_in_data;

    localparam t_sample S_MAX = {1'b0, {(gep_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam t_sample S_MIN = {1'b1, {(gep_pkg::SAMPLE_BITS-1){1'b0}}};

    typedef struct {
        logic [1:0] mode;
        t_sample    left;
        t_sample    right;
        t_index     band;
        logic [1:0] wsel;
        t_word      word;
    } t_eq_item;

    typedef struct {
        t_sample left;
        t_sample right;
    } t_frame;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    wire                               s_axis_tready;
    logic [gep_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic [gep_pkg::IN_USER_W-1:0]     s_axis_tuser;
    wire                               m_axis_tvalid;
    logic                              m_axis_tready;
    wire  [gep_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                              i_cfg_we;
    logic [gep_pkg::REG_IDX_W-1:0]     i_cfg_addr;
    logic [gep_pkg::REG_DATA_W-1:0]    i_cfg_wdata;

    // equalizer state as predicted
    logic                           eq_enable;
    logic [gep_pkg::COUNT_BITS-1:0] eq_band_count;
    t_sample x_hist1   [2][gep_pkg::MAX_BANDS];
    t_sample x_hist2   [2][gep_pkg::MAX_BANDS];
    t_band   y_hist1   [2][gep_pkg::MAX_BANDS];
    t_band   y_hist2   [2][gep_pkg::MAX_BANDS];
    t_word   coef_c1   [gep_pkg::MAX_BANDS];
    t_word   coef_c2   [gep_pkg::MAX_BANDS];
    t_word   coef_c3   [gep_pkg::MAX_BANDS];
    t_word   band_gain [gep_pkg::MAX_BANDS];

    t_frame expected_frames[$];

    int   mismatch_count = 0;
    int   frames_checked = 0;
    int   loads_sent     = 0;
    int   clears_sent    = 0;
    int   reg_writes     = 0;
    logic no_idle        = 1'b0;
    logic hold_request   = 1'b0;

    parallel_bandpass_graphic_equalizer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void clear_history();
        for (int ch = 0; ch < 2; ch++) begin
            for (int b = 0; b < gep_pkg::MAX_BANDS; b++) begin
                x_hist1[ch][b] = '0;
                x_hist2[ch][b] = '0;
                y_hist1[ch][b] = '0;
                y_hist2[ch][b] = '0;
            end
        end
    endfunction

    function automatic void reset_equalizer();
        eq_enable     = 1'b0;
        eq_band_count = gep_pkg::BAND_COUNT_RESET;
        clear_history();
        for (int b = 0; b < gep_pkg::MAX_BANDS; b++) begin
            coef_c1[b]   = '0;
            coef_c2[b]   = '0;
            coef_c3[b]   = '0;
            band_gain[b] = gep_pkg::GAIN_RESET;
        end
    endfunction

    function automatic t_wide saturate(input t_wide v, input int bits);
        t_wide hi, lo;
        hi = t_wide'(1);
        hi = (hi <<< (bits - 1)) - t_wide'(1);
        lo = -hi - t_wide'(1);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic count_valid();
        return (eq_band_count == 10 || eq_band_count == 15 || eq_band_count == 25 ||
                eq_band_count == 31) && eq_band_count <= gep_pkg::MAX_BANDS;
    endfunction

    // one channel through all active bands, weighted sum of band outputs
    function automatic t_sample filter_lane(input int ch, input t_sample x);
        t_wide acc, total, y, w_c1, w_c2, w_c3, w_y1, w_y2, w_x, w_x2, w_g;
        t_wide half_band, half_gain;
        half_band = t_wide'(1);
        half_band = half_band <<< (gep_pkg::COEF_FRAC - 1);
        half_gain = t_wide'(1);
        half_gain = half_gain <<< (gep_pkg::GAIN_FRAC - 1);
        total = '0;
        w_x = x;
        for (int b = 0; b < eq_band_count; b++) begin
            w_c1 = coef_c1[b];
            w_c2 = coef_c2[b];
            w_c3 = coef_c3[b];
            w_y1 = y_hist1[ch][b];
            w_y2 = y_hist2[ch][b];
            w_x2 = x_hist2[ch][b];
            acc  = w_c3 * w_y1 + w_c2 * (w_x - w_x2) - w_c1 * w_y2;
            y    = saturate((acc + half_band) >>> gep_pkg::COEF_FRAC, gep_pkg::BAND_BITS);
            x_hist2[ch][b] = x_hist1[ch][b];
            x_hist1[ch][b] = x;
            y_hist2[ch][b] = y_hist1[ch][b];
            y_hist1[ch][b] = y[gep_pkg::BAND_BITS-1:0];
            w_g   = band_gain[b];
            total = total + y * w_g;
        end
        acc = saturate((total + half_gain) >>> gep_pkg::GAIN_FRAC, gep_pkg::SAMPLE_BITS);
        return acc[gep_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic void apply_item(input t_eq_item it);
        t_frame fr;
        case (it.mode)
            gep_pkg::MODE_FRAME: begin
                fr.left  = it.left;
                fr.right = it.right;
                if (eq_enable && count_valid()) begin
                    fr.left  = filter_lane(0, it.left);
                    fr.right = filter_lane(1, it.right);
                end
                expected_frames.push_back(fr);
            end
            gep_pkg::MODE_LOAD: begin
                loads_sent++;
                if (it.band < gep_pkg::MAX_BANDS) begin
                    case (it.wsel)
                        gep_pkg::WSEL_C1:   coef_c1[it.band]   = it.word;
                        gep_pkg::WSEL_C2:   coef_c2[it.band]   = it.word;
                        gep_pkg::WSEL_C3:   coef_c3[it.band]   = it.word;
                        gep_pkg::WSEL_GAIN: band_gain[it.band] = it.word;
                        default: ;
                    endcase
                end
            end
            gep_pkg::MODE_CLEAR: begin
                clears_sent++;
                clear_history();
            end
            default: ;
        endcase
    endfunction

    function automatic t_eq_item frame_item(input t_sample l, input t_sample r);
        t_eq_item it;
        it.mode  = gep_pkg::MODE_FRAME;
        it.left  = l;
        it.right = r;
        it.band  = t_index'($urandom);
        it.wsel  = 2'($urandom);
        it.word  = $urandom;
        return it;
    endfunction

    function automatic t_eq_item load_item(input t_index band,
                                           input logic [1:0] wsel, input t_word word);
        t_eq_item it;
        it       = frame_item(t_sample'($urandom), t_sample'($urandom));
        it.mode  = gep_pkg::MODE_LOAD;
        it.band  = band;
        it.wsel  = wsel;
        it.word  = word;
        return it;
    endfunction

    function automatic t_eq_item cmd_item(input logic [1:0] mode);
        t_eq_item it;
        it      = frame_item(t_sample'($urandom), t_sample'($urandom));
        it.mode = mode;
        return it;
    endfunction

    // mostly stable sections, now and then an arbitrary word
    function automatic t_word band_word(input logic [1:0] wsel);
        t_word w;
        if ($urandom_range(0, 9) == 0) return $urandom;
        case (wsel)
            gep_pkg::WSEL_C1:   w = $urandom_range(1 << 29, (1 << 30) - 1);
            gep_pkg::WSEL_C2: begin
                w = $urandom_range(0, 1 << 27);
                w = w - (1 << 26);
            end
            gep_pkg::WSEL_C3: begin
                w = $urandom_range(0, 32'h7FFF_FFFF);
                w = w - 32'sh4000_0000;
            end
            default:   w = $urandom_range(0, 1 << 29);
        endcase
        return w;
    endfunction

    function automatic t_eq_item random_item();
        t_eq_item it;
        int       pick;
        it   = frame_item(t_sample'($urandom), t_sample'($urandom));
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 1)) begin
            it.left  = it.left >>> 6;
            it.right = it.right >>> 6;
        end
        if (pick < 55) begin
            it.mode = gep_pkg::MODE_FRAME;
        end else if (pick < 90) begin
            it.mode = gep_pkg::MODE_LOAD;
            it.word = band_word(it.wsel);
        end else if (pick < 95) begin
            it.mode = gep_pkg::MODE_CLEAR;
        end else begin
            it.mode = MODE_NOP;
        end
        return it;
    endfunction

    task automatic send_beat(input t_eq_item it);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 99) < 23) begin
            s_axis_tvalid = 1'b0;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(4, 45)) @(negedge i_clk);
            else
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tdata  = t_in_data'({it.word, it.band, it.right, it.left});
        s_axis_tuser  = {it.wsel, it.mode};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_item(it);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [gep_pkg::REG_IDX_W-1:0] idx, input t_regval val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        if (idx == gep_pkg::REG_ENABLE) begin
            if (val[0] && !eq_enable) clear_history();
            eq_enable = val[0];
        end else begin
            eq_band_count = val;
        end
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_passthrough();
        send_beat(frame_item(S_MIN, S_MAX));
        send_beat(frame_item(S_MAX, S_MIN));
        send_beat(frame_item('0, '1));
        settle();
        cfg_write(gep_pkg::REG_ENABLE, 5'd1);
        cfg_write(gep_pkg::REG_BAND_COUNT, 5'd0);
        send_beat(frame_item(S_MIN, S_MAX));
        settle();
        cfg_write(gep_pkg::REG_BAND_COUNT, 5'd30);
        send_beat(frame_item(S_MAX, t_sample'(12345)));
    endtask

    task automatic test_word_loads();
        send_beat(load_item('0, gep_pkg::WSEL_C1, '0));
        send_beat(load_item('0, gep_pkg::WSEL_C2, 32'sh4000_0000));
        send_beat(load_item('0, gep_pkg::WSEL_C3, '0));
        send_beat(load_item('0, gep_pkg::WSEL_GAIN, 32'sh1000_0000));
        send_beat(load_item(t_index'(gep_pkg::MAX_BANDS - 1), gep_pkg::WSEL_C1,
                            32'sh8000_0000));
        send_beat(load_item(t_index'(gep_pkg::MAX_BANDS - 1), gep_pkg::WSEL_C2,
                            32'sh7FFF_FFFF));
        send_beat(load_item(t_index'(gep_pkg::MAX_BANDS - 1), gep_pkg::WSEL_C3,
                            32'sh7FFF_FFFF));
        send_beat(load_item(t_index'(gep_pkg::MAX_BANDS - 1), gep_pkg::WSEL_GAIN,
                            32'sh7FFF_FFFF));
        // band past the last one, must be dropped
        send_beat(load_item(t_index'(gep_pkg::MAX_BANDS), gep_pkg::WSEL_GAIN, '0));
        send_beat(cmd_item(MODE_NOP));
    endtask

    task automatic test_filter_extremes();
        settle();
        cfg_write(gep_pkg::REG_BAND_COUNT, 5'd31);
        send_beat(frame_item(S_MAX, S_MIN));
        send_beat(frame_item(S_MAX, S_MIN));
        send_beat(frame_item(S_MIN, S_MAX));
        send_beat(cmd_item(gep_pkg::MODE_CLEAR));
        send_beat(frame_item(S_MAX, S_MAX));
        send_beat(frame_item(S_MIN, S_MIN));
        settle();
        cfg_write(gep_pkg::REG_BAND_COUNT, 5'd10);
        send_beat(frame_item(S_MIN, t_sample'(1)));
    endtask

    task automatic test_output_stall();
        t_eq_item it;
        settle();
        cfg_write(gep_pkg::REG_BAND_COUNT, 5'd10);
        cfg_write(gep_pkg::REG_ENABLE, 5'd1);
        hold_request = 1'b1;
        repeat (32) begin
            it      = random_item();
            it.mode = gep_pkg::MODE_FRAME;
            send_beat(it);
        end
    endtask

    task automatic test_random_traffic(input int total);
        int      done;
        int      phase;
        logic    en;
        t_regval cnt;
        t_regval val;
        done  = 0;
        phase = 0;
        while (done < total) begin
            settle();
            case (phase)
                0: begin en = 1'b1; cnt = 5'd31; end
                1: begin en = 1'b0; cnt = 5'd10; end
                2: begin en = 1'b1; cnt = 5'd15; end
                3: begin en = 1'b1; cnt = 5'd25; end
                4: begin en = 1'b1; cnt = 5'd0;  end
                default: begin
                    en = $urandom_range(0, 9) != 0;
                    case ($urandom_range(0, 4))
                        0: cnt = 5'd10;
                        1: cnt = 5'd15;
                        2: cnt = 5'd25;
                        3: cnt = 5'd31;
                        default: cnt = t_regval'($urandom);
                    endcase
                end
            endcase
            if ($urandom_range(0, 1)) begin
                val    = t_regval'($urandom);
                val[0] = 1'b0;
                cfg_write(gep_pkg::REG_ENABLE, val);
            end
            val    = t_regval'($urandom);
            val[0] = en;
            cfg_write(gep_pkg::REG_ENABLE, val);
            cfg_write(gep_pkg::REG_BAND_COUNT, cnt);
            no_idle = (phase == 2);
            repeat (125) send_beat(random_item());
            no_idle = 1'b0;
            done += 125;
            phase++;
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request  = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = no_idle || ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_frame  want;
        t_sample got_l;
        t_sample got_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_l = m_axis_tdata[gep_pkg::SAMPLE_BITS-1:0];
            got_r = m_axis_tdata[2*gep_pkg::SAMPLE_BITS-1:gep_pkg::SAMPLE_BITS];
            if (expected_frames.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with none expected, left %0d right %0d",
                         $time, got_l, got_r);
            end else begin
                want = expected_frames.pop_front();
                frames_checked++;
                if (got_l !== want.left) begin
                    mismatch_count++;
                    $display("%0t: left_out expected %0d actual %0d",
                             $time, want.left, got_l);
                end
                if (got_r !== want.right) begin
                    mismatch_count++;
                    $display("%0t: right_out expected %0d actual %0d",
                             $time, want.right, got_r);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        reset_equalizer();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_passthrough();
        test_word_loads();
        test_filter_extremes();
        test_output_stall();
        test_random_traffic(1375);
        settle();

        $display("run covered %0d checked frames, %0d band word loads, %0d history clears",
                 frames_checked, loads_sent, clears_sent);
        $display("and %0d register writes across pass-through and 10/15/25/31 band settings",
                 reg_writes);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
